// ----- rtl/bxd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd_pkg
// Shared constants and types of the box average downscaler.
// ----------------------------------------------------------------------------
package bxd_pkg;

  localparam int SCALE_FACTOR   = 2;
  localparam int MAX_ROW_PIXELS = 2048;
  localparam int STORE_DEPTH    = MAX_ROW_PIXELS / 2;
  localparam int BLOCK_AREA     = SCALE_FACTOR * SCALE_FACTOR;

  localparam int PIX_W   = 8;
  localparam int WIDTH_W = 12;
  localparam int COL_W   = $clog2(MAX_ROW_PIXELS);
  localparam int CMP_W   = 14;
  localparam int SUB_W   = (SCALE_FACTOR > 1) ? $clog2(SCALE_FACTOR) : 1;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int HSUM_W  = 11;
  localparam int VSUM_W  = 14;
  localparam int PHASE_W = 3;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd1920;

  // One closed block of a row, on its way to the column-sum stage.
  typedef struct packed {
    logic [HSUM_W-1:0] hsum;
    logic [ADDR_W-1:0] addr;
    logic              use_store;
    logic              store_ok;
    logic              band_last;
    logic              row_end;
  } bxd_blk_t;

  // Read request to the column-sum memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } bxd_rd_t;

  // Write request to the column-sum memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VSUM_W-1:0] data;
  } bxd_wr_t;

endpackage

// ----- rtl/bxd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bxd_ram #(
  parameter int Width = 14,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bxd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd_ctrl
// Raster position counters, horizontal block sum and width register.
// ----------------------------------------------------------------------------
module bxd_ctrl
  import bxd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [WIDTH_W-1:0] cfg_wr_data_i,
  input  logic               accept_i,
  input  logic [PIX_W-1:0]   pixel_in_i,
  input  logic               frame_start_i,
  output logic               blk_valid_o,
  output bxd_blk_t           blk_o,
  output bxd_rd_t            rd_o
);

  logic [WIDTH_W-1:0] width_q;
  logic [COL_W-1:0]   col_q, col_d, col_c;
  logic [SUB_W-1:0]   sub_q, sub_d, sub_c;
  logic [COL_W-1:0]   blk_q, blk_d, blk_c;
  logic [HSUM_W-1:0]  hsum_q, hsum_d, hsum_c;
  logic [PHASE_W-1:0] phase_q, phase_d, phase_c;
  logic [CMP_W-1:0]   col_p1;
  logic               row_end, sub_last, block_end, band_last, store_ok;

  always_comb begin
    // A frame start restarts the counters before this pixel is taken.
    col_c   = frame_start_i ? '0 : col_q;
    sub_c   = frame_start_i ? '0 : sub_q;
    blk_c   = frame_start_i ? '0 : blk_q;
    phase_c = frame_start_i ? '0 : phase_q;

    col_p1    = CMP_W'(col_c) + CMP_W'(1);
    row_end   = (col_p1 >= CMP_W'(width_q)) || (col_p1 >= CMP_W'(MAX_ROW_PIXELS));
    sub_last  = (sub_c == SUB_W'(SCALE_FACTOR - 1));
    block_end = sub_last || row_end;
    band_last = (phase_c >= PHASE_W'(SCALE_FACTOR - 1));
    store_ok  = ({1'b0, blk_c} < (COL_W + 1)'(STORE_DEPTH));

    hsum_c = (sub_c == '0) ? HSUM_W'(pixel_in_i)
                           : hsum_q + HSUM_W'(pixel_in_i);

    hsum_d = block_end ? '0 : hsum_c;
    if (row_end) begin
      col_d   = '0;
      sub_d   = '0;
      blk_d   = '0;
      phase_d = band_last ? '0 : phase_c + PHASE_W'(1);
    end else begin
      col_d   = col_c + COL_W'(1);
      sub_d   = sub_last ? '0 : sub_c + SUB_W'(1);
      blk_d   = sub_last ? blk_c + COL_W'(1) : blk_c;
      phase_d = phase_c;
    end

    blk_valid_o         = accept_i && block_end;
    blk_o.hsum          = hsum_c;
    blk_o.addr          = blk_c[ADDR_W-1:0];
    blk_o.store_ok      = store_ok;
    blk_o.use_store     = store_ok && (phase_c != '0);
    blk_o.band_last     = band_last;
    blk_o.row_end       = row_end;

    rd_o.en   = blk_valid_o && blk_o.use_store;
    rd_o.addr = blk_c[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      col_q   <= '0;
      sub_q   <= '0;
      blk_q   <= '0;
      hsum_q  <= '0;
      phase_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        width_q <= cfg_wr_data_i;
      end
      if (accept_i) begin
        col_q   <= col_d;
        sub_q   <= sub_d;
        blk_q   <= blk_d;
        hsum_q  <= hsum_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

// ----- rtl/bxd_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd_accum
// Adds the stored column sum to a closed block, writes it back or emits
// the block average through the output register.
// ----------------------------------------------------------------------------
module bxd_accum
  import bxd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              blk_valid_i,
  input  bxd_blk_t          blk_i,
  input  bxd_rd_t           rd_i,
  input  logic [VSUM_W-1:0] rdata_i,
  output bxd_wr_t           wr_o,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  pixel_out_o,
  output logic              row_last_o
);

  logic              p1_valid_q;
  bxd_blk_t          p1_q;
  logic              fwd_q;
  logic [VSUM_W-1:0] fwd_data_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  pixel_q;
  logic              row_last_q;
  logic [VSUM_W-1:0] stored;
  logic [VSUM_W-1:0] vsum;
  logic              emit;

  always_comb begin
    // A write in the same cycle as the read of that entry is not seen by
    // the memory's read port, so its data is taken from the bypass.
    stored = fwd_q ? fwd_data_q : rdata_i;
    vsum   = VSUM_W'(p1_q.hsum) + (p1_q.use_store ? stored : '0);
    emit   = p1_valid_q && p1_q.band_last;

    advance_o = !(emit && out_valid_q && out_stall_i);

    wr_o.en   = p1_valid_q && !p1_q.band_last && p1_q.store_ok;
    wr_o.addr = p1_q.addr;
    wr_o.data = vsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        p1_valid_q <= blk_valid_i;
      end
      if (advance_o && rd_i.en) begin
        fwd_q <= wr_o.en && (wr_o.addr == rd_i.addr);
      end
      if (emit && advance_o) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      p1_q <= blk_i;
    end
    if (advance_o && rd_i.en) begin
      fwd_data_q <= wr_o.data;
    end
    if (emit && advance_o) begin
      pixel_q    <= PIX_W'(vsum / BLOCK_AREA);
      row_last_q <= p1_q.row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign row_last_o  = row_last_q;

endmodule

// ----- rtl/box_average_downscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscaler
// Shrinks one 8-bit plane by the scale factor in both directions with a
// box average over each non-overlapping block.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o,
// pixel_in_i, frame_start_i); frame_start_i marks the first pixel of a frame.
// Block averages leave on the output channel (out_valid_o, out_stall_i,
// pixel_out_o, row_last_o), one per block on the last row of each band,
// with row_last_o on the last block of an output row.
// The row width is set through cfg_wr_en_i/cfg_wr_data_i while idle;
// the user must keep to this, as the block does not enforce it.
// Throughput is one item per cycle while in_stall_o is low. The column-sum
// memory is read as the item closing a block is accepted; the block then
// passes the memory stage and its average enters the output register.
// The column sums live in a memory with one read and one write port; a
// write-to-read bypass covers a read of the entry written in that cycle.
// Reset clears the counters and the pipeline and loads the width 1920; the
// memory is not cleared, as the first row of a band only writes it.
// While the receiver stalls, one more closing item is held in the memory
// stage; after that in_stall_o rises until the output register drains.
// ----------------------------------------------------------------------------
module box_average_downscaler
  import bxd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [WIDTH_W-1:0] cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIX_W-1:0]   pixel_in_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   pixel_out_o,
  output logic               row_last_o
);

  logic              advance;
  logic              accept;
  logic              blk_valid;
  bxd_blk_t          blk;
  bxd_rd_t           rd;
  bxd_wr_t           wr;
  logic [VSUM_W-1:0] rdata;

  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  bxd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .accept_i      (accept),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .blk_valid_o   (blk_valid),
    .blk_o         (blk),
    .rd_o          (rd)
  );

  bxd_ram #(
    .Width (VSUM_W),
    .Depth (STORE_DEPTH)
  ) u_colsum_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  bxd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_i       (blk),
    .rd_i        (rd),
    .rdata_i     (rdata),
    .wr_o        (wr),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .row_last_o  (row_last_o)
  );

endmodule

// ----- rtl/bxd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd_checker
// Port-level checks of the box average downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bxd_checker
  import bxd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] pixel_out_o,
  input logic             row_last_o
);

  // The input side only waits while a result is held by the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output item");

  // A newly raised result follows an accepted item through the memory stage and the output register.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output item without a matching input item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(pixel_out_o) && $stable(row_last_o)))
    else $error("output item changed while stalled");

endmodule

bind box_average_downscaler bxd_checker u_bxd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o),
  .row_last_o  (row_last_o)
);

// ----- tb/box_average_downscaler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscaler_tb
// Streams pixel frames of many widths through the box average downscaler and
// checks every block average and row-last flag against a cycle-free
// prediction of the block, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module box_average_downscaler_tb;
  import bxd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 900;
  localparam int SHORT_ROW    = 48;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;
  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREME} fill_e;

  typedef struct packed {
    logic [PIX_W-1:0] avg;
    logic             last;
  } avg_item_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_wr_en_i   = 1'b0;
  logic [WIDTH_W-1:0] cfg_wr_data_i = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [PIX_W-1:0]   pixel_in_i    = '0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [PIX_W-1:0]   pixel_out_o;
  logic               row_last_o;

  // Predicted state of the downscaler.
  logic [WIDTH_W-1:0] pred_width = WIDTH_RESET;
  logic [COL_W-1:0]   pred_col   = '0;
  logic [PHASE_W-1:0] pred_phase = '0;
  logic [HSUM_W-1:0]  pred_hsum  = '0;
  logic [VSUM_W-1:0]  pred_col_sums [STORE_DEPTH];

  avg_item_t expected_avgs [$];
  avg_item_t exp_item;

  int unsigned error_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned avgs_checked  = 0;
  int unsigned frames_sent   = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned mode_left     = 0;
  int unsigned hold_left     = 0;
  bit          gaps_enabled  = 1'b1;
  bit          hold_req      = 1'b0;
  stall_mode_e stall_mode    = STALL_NONE;

  box_average_downscaler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .row_last_o    (row_last_o)
  );

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d averages still expected",
               $time, cycle_count, expected_avgs.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: a long hold when asked for, otherwise a changing stall pattern.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
        default:      out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_avgs.size() == 0) begin
        error_count++;
        $display("%0t MISMATCH unexpected item: expected none, actual avg %0d row_last %0b",
                 $time, pixel_out_o, row_last_o);
      end else begin
        exp_item = expected_avgs.pop_front();
        avgs_checked++;
        if (pixel_out_o !== exp_item.avg) begin
          error_count++;
          $display("%0t MISMATCH pixel_out: expected %0d, actual %0d",
                   $time, exp_item.avg, pixel_out_o);
        end
        if (row_last_o !== exp_item.last) begin
          error_count++;
          $display("%0t MISMATCH row_last: expected %0b, actual %0b",
                   $time, exp_item.last, row_last_o);
        end
      end
    end
  end

  // Advances the predicted state by one pixel and queues the block average
  // that the pixel closes on the last row of a band.
  function automatic void predict_box_average(input logic [PIX_W-1:0] pix, input logic fs);
    int        col;
    int        sub;
    int        blk;
    bit        row_end;
    bit        block_end;
    bit        band_last;
    logic [VSUM_W-1:0] vsum;
    avg_item_t item;
    if (fs) begin
      pred_col   = '0;
      pred_phase = '0;
      pred_hsum  = '0;
    end
    col       = int'(pred_col);
    sub       = col % SCALE_FACTOR;
    blk       = col / SCALE_FACTOR;
    row_end   = (col + 1 >= int'(pred_width)) || (col + 1 >= MAX_ROW_PIXELS);
    block_end = (sub == SCALE_FACTOR - 1) || row_end;
    band_last = (int'(pred_phase) >= SCALE_FACTOR - 1);
    if (sub == 0) begin
      pred_hsum = HSUM_W'(pix);
    end else begin
      pred_hsum = pred_hsum + HSUM_W'(pix);
    end
    if (block_end) begin
      vsum = VSUM_W'(pred_hsum);
      if (pred_phase != '0 && blk < STORE_DEPTH) begin
        vsum = vsum + pred_col_sums[blk];
      end
      if (band_last) begin
        item.avg  = PIX_W'(vsum / BLOCK_AREA);
        item.last = row_end;
        expected_avgs.push_back(item);
      end else if (blk < STORE_DEPTH) begin
        pred_col_sums[blk] = vsum;
      end
      pred_hsum = '0;
    end
    if (row_end) begin
      pred_col   = '0;
      pred_phase = band_last ? '0 : pred_phase + PHASE_W'(1);
    end else begin
      pred_col = COL_W'(col + 1);
    end
  endfunction

  // Offers one item and returns once it has been taken; between bursts the
  // valid drops for a random gap.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_box_average(pix, fs);
    pixels_sent++;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 48);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] width);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= width;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    pred_width = width;
  endtask

  // Sends rows of the current width; cut drops that many pixels from the end,
  // stray_pct sprinkles frame starts into the middle of the frame.
  task automatic send_frame(input int rows, input fill_e fill, input int cut,
                            input bit with_start, input int stray_pct);
    int               row_px;
    int               total;
    logic [PIX_W-1:0] pix;
    logic             fs;
    row_px = (int'(pred_width) <= 1) ? 1 :
             (int'(pred_width) > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(pred_width);
    total  = row_px * rows - cut;
    frames_sent++;
    for (int i = 0; i < total; i++) begin
      case (fill)
        FILL_WHITE:   pix = '1;
        FILL_BLACK:   pix = '0;
        FILL_EXTREME: pix = $urandom_range(0, 1) ? '1 : '0;
        default:      pix = PIX_W'($urandom_range(0, 255));
      endcase
      fs = (i == 0) ? with_start : ($urandom_range(0, 99) < stray_pct);
      send_pixel(pix, fs);
    end
  endtask

  // With the reset width a short first row stays open, so nothing comes out.
  task automatic test_reset_width();
    send_frame(1, FILL_RANDOM, int'(WIDTH_RESET) - SHORT_ROW, 1'b1, 0);
  endtask

  task automatic test_block_extremes();
    set_width(WIDTH_W'(2));
    send_frame(2, FILL_WHITE, 0, 1'b1, 0);
    send_frame(2, FILL_BLACK, 0, 1'b1, 0);
    set_width(WIDTH_W'(4));
    send_frame(2, FILL_EXTREME, 0, 1'b1, 0);
  endtask

  // A width that is not a multiple of the factor closes a narrow last block.
  task automatic test_odd_widths();
    set_width(WIDTH_W'(3));
    send_frame(2, FILL_WHITE, 0, 1'b1, 0);
    set_width(WIDTH_W'(5));
    send_frame(2, FILL_RANDOM, 0, 1'b1, 0);
  endtask

  // Widths of zero and one end a row on every pixel.
  task automatic test_tiny_widths();
    set_width(WIDTH_W'(1));
    send_frame(4, FILL_EXTREME, 0, 1'b1, 0);
    set_width(WIDTH_W'(0));
    send_frame(4, FILL_RANDOM, 0, 1'b1, 0);
  endtask

  // A frame start in the middle of a band throws the partial band away.
  task automatic test_frame_restart();
    set_width(WIDTH_W'(4));
    send_frame(2, FILL_WHITE, 2, 1'b1, 0);
    send_frame(2, FILL_RANDOM, 0, 1'b1, 0);
  endtask

  // Widths at the row maximum and past it keep a short first row open.
  task automatic test_wide_rows();
    set_width(WIDTH_W'(MAX_ROW_PIXELS));
    send_frame(1, FILL_RANDOM, MAX_ROW_PIXELS - SHORT_ROW, 1'b1, 0);
    set_width('1);
    send_frame(1, FILL_EXTREME, MAX_ROW_PIXELS - SHORT_ROW, 1'b1, 0);
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_output_hold();
    set_width(WIDTH_W'(8));
    gaps_enabled = 1'b0;
    hold_req     = 1'b1;
    send_frame(8, FILL_RANDOM, 0, 1'b1, 0);
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned start_count;
    int unsigned pick;
    int          rows;
    int          cut;
    bit          width_change;
    logic [WIDTH_W-1:0] width;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      pick         = $urandom_range(0, 99);
      width_change = ($urandom_range(0, 1) == 1);
      if (pick < 65) begin
        width = WIDTH_W'(2 * $urandom_range(1, 16));
      end else if (pick < 78) begin
        width = WIDTH_W'(2 * $urandom_range(1, 15) + 1);
      end else if (pick < 84) begin
        width = WIDTH_W'($urandom_range(0, 1));
      end else begin
        width = WIDTH_W'($urandom_range(34, 64));
      end
      gaps_enabled = ($urandom_range(0, 3) != 0);
      rows = $urandom_range(1, 6);
      cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (width_change) begin
        set_width(width);
      end
      // With the width unchanged a frame may simply run on without a start.
      send_frame(rows, ($urandom_range(0, 5) == 0) ? FILL_EXTREME : FILL_RANDOM, cut,
                 width_change || ($urandom_range(0, 2) != 0),
                 ($urandom_range(0, 3) == 0) ? 2 : 0);
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) pred_col_sums[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_width();
    test_block_extremes();
    test_odd_widths();
    test_tiny_widths();
    test_frame_restart();
    test_wide_rows();
    test_output_hold();
    test_random_frames();

    wait_idle();
    $display("Sent %0d pixels in %0d frames and checked %0d block averages,",
             pixels_sent, frames_sent, avgs_checked);
    $display("over widths 0 to 4095, frame restarts and a long output hold; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- box_average_downscaler.f -----
rtl/bxd_pkg.sv
rtl/bxd_ram.sv
rtl/bxd_ctrl.sv
rtl/bxd_accum.sv
rtl/box_average_downscaler.sv
rtl/bxd_checker.sv
tb/box_average_downscaler_tb.sv
